[sv/tun_pkg.sv]
// Shared types for the triangle unit normal pipeline.
package tun_pkg;

  // Control that travels with an item through the pipeline.
  typedef struct packed {
    logic       vld;
    logic       degen;
    logic [2:0] neg;
  } ctl_t;

endpackage

[sv/triangle_unit_normal_top.sv]
// Triangle unit normal: edges, cross product, exact scaling to Q1.(NORMAL_BITS-1).
// Throughput: one triangle per cycle; busy stays low, done pulses once per item.
// The pipeline holds a restoring divider (2*NORMAL_BITS+1 stages, one quotient
// bit each) and the integer square root (NORMAL_BITS+1 stages, one root bit each).
// Reset (rst, synchronous) clears the valid bits; items in flight are dropped.
module triangle_unit_normal_top #(
  parameter int COORD_BITS  = 24,
  parameter int NORMAL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  vert_a_x,
  input  logic signed [COORD_BITS-1:0]  vert_a_y,
  input  logic signed [COORD_BITS-1:0]  vert_a_z,
  input  logic signed [COORD_BITS-1:0]  vert_b_x,
  input  logic signed [COORD_BITS-1:0]  vert_b_y,
  input  logic signed [COORD_BITS-1:0]  vert_b_z,
  input  logic signed [COORD_BITS-1:0]  vert_c_x,
  input  logic signed [COORD_BITS-1:0]  vert_c_y,
  input  logic signed [COORD_BITS-1:0]  vert_c_z,
  output logic                          done,
  output logic signed [NORMAL_BITS-1:0] norm_x,
  output logic signed [NORMAL_BITS-1:0] norm_y,
  output logic signed [NORMAL_BITS-1:0] norm_z,
  output logic                          degenerate
);

  localparam int EB  = COORD_BITS + 1;      // edge width
  localparam int PB  = 2 * EB;              // product width
  localparam int NB  = PB + 1;              // cross component width
  localparam int MB  = PB;                  // magnitude width
  localparam int H   = (MB + 1) / 2;        // low half of magnitude
  localparam int HB  = MB - H;              // high half of magnitude
  localparam int SQ  = 2 * MB;              // magnitude squared
  localparam int SB  = SQ + 2;              // sum of squares
  localparam int RB  = SB + 1;              // divider remainder
  localparam int F   = NORMAL_BITS - 1;
  localparam int KB  = 2 * F + 3;           // quotient bits
  localparam int P   = F + 2;               // root bits
  localparam int W   = 2 * P;               // root datapath width
  localparam int LAT = 8 + KB + P;

  // stage 1: edges
  logic signed [EB-1:0] eu [3];
  logic signed [EB-1:0] ev [3];
  logic                 s1_vld;
  // stage 2: products
  logic signed [PB-1:0] prod [6];
  logic                 s2_vld;
  // stage 3: cross product
  logic signed [NB-1:0] crs [3];
  logic                 s3_vld;
  // stage 4: magnitudes
  logic [MB-1:0]        mag [3];
  tun_pkg::ctl_t        s4_ctl;
  // stage 5: partial products
  logic [2*H-1:0]       pll [3];
  logic [H+HB-1:0]      phl [3];
  logic [2*HB-1:0]      phh [3];
  tun_pkg::ctl_t        s5_ctl;
  // stage 6: squares
  logic [SQ-1:0]        msq [3];
  tun_pkg::ctl_t        s6_ctl;
  // stage 7: sum of squares
  logic [SQ-1:0]        s7_msq [3];
  logic [SB-1:0]        s7_sum;
  tun_pkg::ctl_t        s7_ctl;
  // divider pipeline
  logic [RB-1:0]        drem [1:KB][3];
  logic [KB-1:0]        dquo [1:KB][3];
  logic [SB-1:0]        dsum [1:KB];
  tun_pkg::ctl_t        dctl [1:KB];
  // root pipeline
  logic [W-1:0]         sx [1:P][3];
  logic [W-1:0]         sy [1:P][3];
  tun_pkg::ctl_t        sctl [1:P];
  // output
  logic [W-1:0]         rp1 [3];
  logic [F:0]           qv [3];
  logic [NORMAL_BITS-1:0] enc [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    eu[0] <= EB'(vert_b_x) - EB'(vert_a_x);
    eu[1] <= EB'(vert_b_y) - EB'(vert_a_y);
    eu[2] <= EB'(vert_b_z) - EB'(vert_a_z);
    ev[0] <= EB'(vert_c_x) - EB'(vert_a_x);
    ev[1] <= EB'(vert_c_y) - EB'(vert_a_y);
    ev[2] <= EB'(vert_c_z) - EB'(vert_a_z);
    prod[0] <= eu[1] * ev[2];
    prod[1] <= eu[2] * ev[1];
    prod[2] <= eu[2] * ev[0];
    prod[3] <= eu[0] * ev[2];
    prod[4] <= eu[0] * ev[1];
    prod[5] <= eu[1] * ev[0];
    crs[0] <= NB'(prod[0]) - NB'(prod[1]);
    crs[1] <= NB'(prod[2]) - NB'(prod[3]);
    crs[2] <= NB'(prod[4]) - NB'(prod[5]);
    s4_ctl.vld   <= s3_vld && !rst;
    s4_ctl.degen <= (crs[0] == '0) && (crs[1] == '0) && (crs[2] == '0);
    for (int c = 0; c < 3; c++) begin
      s4_ctl.neg[c] <= crs[c][NB-1];
      mag[c] <= crs[c][NB-1] ? MB'(-crs[c]) : MB'(crs[c]);
      pll[c] <= mag[c][H-1:0] * mag[c][H-1:0];
      phl[c] <= mag[c][MB-1:H] * mag[c][H-1:0];
      phh[c] <= mag[c][MB-1:H] * mag[c][MB-1:H];
      msq[c] <= (SQ'(phh[c]) << (2 * H)) + (SQ'(phl[c]) << (H + 1)) + SQ'(pll[c]);
      s7_msq[c] <= msq[c];
    end
    s5_ctl.vld   <= s4_ctl.vld && !rst;
    s5_ctl.degen <= s4_ctl.degen;
    s5_ctl.neg   <= s4_ctl.neg;
    s6_ctl.vld   <= s5_ctl.vld && !rst;
    s6_ctl.degen <= s5_ctl.degen;
    s6_ctl.neg   <= s5_ctl.neg;
    s7_ctl.vld   <= s6_ctl.vld && !rst;
    s7_ctl.degen <= s6_ctl.degen;
    s7_ctl.neg   <= s6_ctl.neg;
    s7_sum <= SB'(msq[0]) + SB'(msq[1]) + SB'(msq[2]);
    s1_vld <= start && !busy && !rst;
    s2_vld <= s1_vld && !rst;
    s3_vld <= s2_vld && !rst;
  end

  // One quotient bit per stage: K = floor(m^2 * 4^(F+1) / sum).
  for (genvar g = 0; g < KB; g++) begin : g_div
    logic [RB-1:0] rem_in [3];
    logic [KB-1:0] quo_in [3];
    logic [SB-1:0] sum_in;
    tun_pkg::ctl_t ctl_in;
    logic [RB-1:0] trial  [3];
    logic          take   [3];
    if (g == 0) begin : g_in
      // Remainder starts at m^2, which never exceeds the sum.
      always_comb begin
        sum_in = s7_sum;
        ctl_in = s7_ctl;
        for (int c = 0; c < 3; c++) begin
          rem_in[c] = RB'(s7_msq[c]);
          quo_in[c] = '0;
        end
      end
    end else begin : g_in
      always_comb begin
        sum_in = dsum[g];
        ctl_in = dctl[g];
        for (int c = 0; c < 3; c++) begin
          rem_in[c] = drem[g][c];
          quo_in[c] = dquo[g][c];
        end
      end
    end
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = (g == 0) ? rem_in[c] : {rem_in[c][RB-2:0], 1'b0};
        take[c]  = trial[c] >= RB'(sum_in);
      end
    end
    always_ff @(posedge clk) begin
      dsum[g+1]       <= sum_in;
      dctl[g+1].vld   <= ctl_in.vld && !rst;
      dctl[g+1].degen <= ctl_in.degen;
      dctl[g+1].neg   <= ctl_in.neg;
      for (int c = 0; c < 3; c++) begin
        drem[g+1][c] <= take[c] ? trial[c] - RB'(sum_in) : trial[c];
        dquo[g+1][c] <= {quo_in[c][KB-2:0], take[c]};
      end
    end
  end

  // Integer square root, one root bit per stage.
  for (genvar i = 0; i < P; i++) begin : g_sqrt
    localparam logic [W-1:0] BB = {{(W-1){1'b0}}, 1'b1} << (2 * (P - 1 - i));
    logic [W-1:0]  x_in [3];
    logic [W-1:0]  y_in [3];
    tun_pkg::ctl_t ctl_in;
    logic [W-1:0]  cand [3];
    logic          fits [3];
    if (i == 0) begin : g_in
      always_comb begin
        ctl_in = dctl[KB];
        for (int c = 0; c < 3; c++) begin
          x_in[c] = W'(dquo[KB][c]);
          y_in[c] = '0;
        end
      end
    end else begin : g_in
      always_comb begin
        ctl_in = sctl[i];
        for (int c = 0; c < 3; c++) begin
          x_in[c] = sx[i][c];
          y_in[c] = sy[i][c];
        end
      end
    end
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        cand[c] = y_in[c] + BB;
        fits[c] = x_in[c] >= cand[c];
      end
    end
    always_ff @(posedge clk) begin
      sctl[i+1].vld   <= ctl_in.vld && !rst;
      sctl[i+1].degen <= ctl_in.degen;
      sctl[i+1].neg   <= ctl_in.neg;
      for (int c = 0; c < 3; c++) begin
        sx[i+1][c] <= fits[c] ? x_in[c] - cand[c] : x_in[c];
        sy[i+1][c] <= fits[c] ? (y_in[c] >> 1) + BB : y_in[c] >> 1;
      end
    end
  end

  // Largest odd r with r^2 <= K gives q = floor((isqrt(K) + 1) / 2).
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rp1[c] = sy[P][c] + W'(1);
      qv[c]  = rp1[c][F+1:1];
      if (sctl[P].degen) begin
        enc[c] = '0;
      end else if (sctl[P].neg[c]) begin
        enc[c] = NORMAL_BITS'(-qv[c]);
      end else if (qv[c][F]) begin
        enc[c] = {1'b0, {F{1'b1}}};
      end else begin
        enc[c] = NORMAL_BITS'(qv[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    norm_x     <= enc[0];
    norm_y     <= enc[1];
    norm_z     <= enc[2];
    degenerate <= sctl[P].degen;
    done       <= sctl[P].vld && !rst;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("item did not complete at the pipeline latency");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("degenerate item with nonzero normal");

  a_unit_nonzero : assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> norm_x != '0 || norm_y != '0 || norm_z != '0)
    else $error("nondegenerate item with zero normal");

endmodule

[sim/tb_triangle_unit_normal_top.sv]
// Testbench for the triangle unit normal pipeline: directed and random triangles, predicted normals.
`timescale 1ns / 100ps

module tb_triangle_unit_normal_top;

  typedef logic signed [23:0] coord_t;
  typedef coord_t tri_t [9];
  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               deg;
  } normal_t;

  localparam coord_t CMIN = 24'sh800000;
  localparam coord_t CMAX = 24'sh7FFFFF;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst, start, busy, done, degenerate;
  coord_t vin [9];
  logic signed [15:0] norm_x, norm_y, norm_z;

  normal_t normals_due [$];
  int mismatches, cycles, tri_sent, normals_seen, degen_seen;

  triangle_unit_normal_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vert_a_x(vin[0]), .vert_a_y(vin[1]), .vert_a_z(vin[2]),
    .vert_b_x(vin[3]), .vert_b_y(vin[4]), .vert_b_z(vin[5]),
    .vert_c_x(vin[6]), .vert_c_y(vin[7]), .vert_c_z(vin[8]),
    .done(done), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Largest q in [0, 2^15] with (2q-1)^2 * sumsq <= mag^2 * 2^32.
  function automatic logic [15:0] scale_component(input logic [191:0] mag,
                                                  input logic [191:0] sumsq);
    logic [191:0] lim, d;
    logic [16:0] q, t;
    lim = (mag * mag) << 32;
    q = 0;
    for (int b = 15; b >= 0; b--) begin
      t = q | (17'd1 << b);
      d = 2 * t - 1;
      if (d * d * sumsq <= lim) q = t;
    end
    if (q == 17'd32768) return 16'h8000;
    return q[15:0];
  endfunction

  function automatic normal_t face_normal(input tri_t v);
    logic signed [191:0] e1 [3], e2 [3], n [3];
    logic [191:0] mag [3], sumsq;
    logic [15:0] m;
    logic signed [15:0] c [3];
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 192'(signed'(v[3+i])) - 192'(signed'(v[i]));
      e2[i] = 192'(signed'(v[6+i])) - 192'(signed'(v[i]));
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? -n[i] : n[i];
      sumsq += mag[i] * mag[i];
    end
    if (sumsq == 0) begin
      r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      m = scale_component(mag[i], sumsq);
      // +1.0 saturates, -1.0 fits
      if (n[i] < 0) c[i] = -signed'(m);
      else c[i] = (m == 16'h8000) ? 16'sh7FFF : signed'(m);
    end
    r = '{c[0], c[1], c[2], 1'b0};
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, normals_seen);
    mismatches++;
  endtask

  always @(posedge clk) begin
    normal_t w;
    if (!rst && done) begin
      normals_seen++;
      if (normals_due.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = normals_due.pop_front();
        if (degenerate) degen_seen++;
        if (norm_x !== w.nx) report("norm_x", norm_x, w.nx);
        if (norm_y !== w.ny) report("norm_y", norm_y, w.ny);
        if (norm_z !== w.nz) report("norm_z", norm_z, w.nz);
        if (degenerate !== w.deg) report("degenerate", degenerate, w.deg);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  int burst_left;

  task automatic send_triangle(input tri_t v);
    logic b;
    @(negedge clk);
    vin = v;
    start <= 1'b1;
    b = busy;
    @(posedge clk);
    while (b) begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end
    normals_due = {normals_due, face_normal(v)};
    tri_sent++;
    // idle between bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  function automatic coord_t rand_coord(input int spread);
    case (spread)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2047)) - 1024);
      2: return $urandom_range(0, 1) ? CMAX - coord_t'($urandom_range(0, 255))
                                      : CMIN + coord_t'($urandom_range(0, 255));
      default: return coord_t'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  task automatic test_directed();
    tri_t v;
    v = '{0, 0, 0, 256, 0, 0, 0, 256, 0}; send_triangle(v);          // +z, saturates
    v = '{0, 0, 0, 0, 256, 0, 256, 0, 0}; send_triangle(v);          // -z, full scale
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; send_triangle(v);              // +y
    v = '{0, 0, 0, 0, 1, 0, 0, 0, 1}; send_triangle(v);              // +x
    v = '{5, 5, 5, 5, 5, 5, 5, 5, 5}; send_triangle(v);              // all points equal
    v = '{0, 0, 0, 1, 2, 3, 2, 4, 6}; send_triangle(v);              // collinear
    v = '{1, 1, 1, 1, 1, 1, 9, 9, 9}; send_triangle(v);              // two points equal
    v = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}; send_triangle(v);
    v = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX}; send_triangle(v);
    v = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}; send_triangle(v);
    v = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}; send_triangle(v);
    v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}; send_triangle(v);
    v = '{0, 0, 0, 1, 1, 0, 1, 0, 1}; send_triangle(v);              // equal components
    v = '{0, 0, 0, 3, 0, 0, 0, 4, 0}; send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 1}; send_triangle(v);              // 1/sqrt(2) split
    v = '{-1, -1, -1, 0, 0, 0, -1, 0, -1}; send_triangle(v);
    v = '{CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX}; send_triangle(v);
    v = '{CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN}; send_triangle(v);
  endtask

  task automatic test_random_triangles(input int count);
    tri_t v;
    int s;
    for (int k = 0; k < count; k++) begin
      s = $urandom_range(0, 3);
      foreach (v[i]) v[i] = rand_coord(s);
      send_triangle(v);
    end
  endtask

  task automatic test_degenerate_triangles(input int count);
    tri_t v;
    int s, ka, kb;
    for (int k = 0; k < count; k++) begin
      s = $urandom_range(1, 3);
      ka = $signed($urandom_range(0, 6)) - 3;
      kb = $signed($urandom_range(0, 6)) - 3;
      for (int i = 0; i < 3; i++) begin
        v[i] = rand_coord(s) >>> 3;
        v[3+i] = rand_coord(s) >>> 3;
        // c on the line through a and b
        v[6+i] = v[i] + coord_t'(ka) * ((v[3+i] - v[i]) >>> 2) * 0
                 + ((ka < 0) ? v[i] - v[3+i] : v[3+i] - v[i]);
      end
      if (kb == 0) v[3:5] = v[0:2];
      send_triangle(v);
    end
  endtask

  initial begin
    start = 1'b0;
    rst = 1'b1;
    foreach (vin[i]) vin[i] = '0;
    mismatches = 0; cycles = 0; tri_sent = 0; normals_seen = 0; degen_seen = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_triangles(1330);
    test_degenerate_triangles(100);
    @(negedge clk);
    start <= 1'b0;
    wait (normals_due.size() == 0);
    repeat (70) @(posedge clk);
    $display("Sent %0d triangles, checked %0d normals (%0d degenerate)",
             tri_sent, normals_seen, degen_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
